>>> hw/rtl/fpscale_pkg.sv
// shared types and constants for the power-of-two scaling block
package fpscale_pkg;
	localparam int unsigned ExpPos = 23;
	localparam logic [7:0] ExpAllOnes = 8'hff;
	localparam logic signed [9:0] ScaleMax = 10'sd300;
	localparam logic signed [9:0] ScaleMin = -10'sd300;

	// decoded operand, passed from the front end to the rounding stage
	typedef struct packed {
		logic passthru;
		logic sign;
		logic signed [10:0] be;
		logic [23:0] sig;
		logic [31:0] raw;
	} fpscale_dec_t;
endpackage

>>> hw/rtl/fpscale_decode.sv
// unpacks the operand, normalizes subnormals and adds the clamped exponent
module fpscale_decode import fpscale_pkg::*; (
	input  logic [31:0]        value_bits,
	input  logic signed [31:0] scale_exponent,
	output fpscale_dec_t       dec
);
	logic [7:0] efield;
	logic [22:0] mant;
	logic signed [9:0] n;
	logic [4:0] lz;
	logic [23:0] sig;
	logic signed [10:0] be0;

	assign efield = value_bits[30:23];
	assign mant = value_bits[22:0];

	always_comb begin
		if (scale_exponent > 32'(signed'(ScaleMax))) n = ScaleMax;
		else if (scale_exponent < 32'(signed'(ScaleMin))) n = ScaleMin;
		else n = scale_exponent[9:0];
	end

	// leading zero count of the subnormal mantissa
	always_comb begin
		lz = 5'd0;
		for (int i = 0; i < 23; i++) begin
			if (mant[i]) lz = 5'(22 - i);
		end
	end

	always_comb begin
		if (efield == 8'd0) begin
			sig = {mant, 1'b0} << lz;
			be0 = 11'sd0 - 11'(signed'({1'b0, lz}));
		end else begin
			sig = {1'b1, mant};
			be0 = 11'(signed'({1'b0, efield, 1'b0}) >>> 1);
		end
	end

	assign dec.passthru = (efield == ExpAllOnes) || (value_bits[30:0] == 31'd0);
	assign dec.sign = value_bits[31];
	assign dec.be = be0 + 11'(n);
	assign dec.sig = sig;
	assign dec.raw = value_bits;
endmodule

>>> hw/rtl/fpscale_round.sv
// packs the result: passthrough, overflow, normal range, rounded subnormal or signed zero
module fpscale_round import fpscale_pkg::*; (
	input  fpscale_dec_t dec,
	output logic [31:0]  result
);
	logic [10:0] shift;
	logic [4:0] sh;
	logic [23:0] q;
	logic [24:0] rem;
	logic [24:0] half;
	logic [23:0] qr;

	assign shift = 11'sd1 - dec.be;
	assign sh = shift[4:0];
	assign q = dec.sig >> sh;
	// one bit wider than the significand so the halfway point exists at a shift of 25
	assign rem = {1'b0, dec.sig} & ((25'd1 << sh) - 25'd1);
	assign half = 25'd1 << (sh - 5'd1);
	assign qr = q + 24'((rem > half) || (rem == half && q[0]));

	always_comb begin
		if (dec.passthru) result = dec.raw;
		else if (dec.be >= 11'sd255) result = {dec.sign, ExpAllOnes, 23'd0};
		else if (dec.be >= 11'sd1) result = {dec.sign, dec.be[7:0], dec.sig[22:0]};
		else if (shift > 11'd25) result = {dec.sign, 31'd0};
		else result = {dec.sign, 7'd0, qr};
	end
endmodule

>>> hw/rtl/float_power_of_two_scale.sv
// top level of the single-precision power-of-two scaling block
// usage:
//   input channel: value_bits (ieee single) and scale_exponent (signed),
//   qualified by in_valid; in_stall holds the sender off.
//   output channel: result_bits qualified by out_valid; out_stall from
//   the receiver.
//   an accepted item passes an input register, then the decode and
//   rounding logic feeding the result register.
//   throughput is one item per cycle while the receiver does not stall,
//   set by the single pass through the exponent add, alignment shift and round.
//   when the receiver stalls, the result register holds and the input
//   register refills once; in_stall rises only when both are full.
//   reset empties both registers; no item is in flight after reset.
module float_power_of_two_scale import fpscale_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [31:0]        value_bits,
	input  logic signed [31:0] scale_exponent,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [31:0]        result_bits
);
	logic valid_s1;
	logic [31:0] value_s1;
	logic signed [31:0] scale_s1;
	fpscale_dec_t dec;
	logic [31:0] result;
	logic adv_s2;
	logic adv_s1;

	assign adv_s2 = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !adv_s2;
	assign adv_s1 = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= 1'b1;
			else if (adv_s2) valid_s1 <= 1'b0;
			if (adv_s2) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			value_s1 <= value_bits;
			scale_s1 <= scale_exponent;
		end
		if (adv_s2) result_bits <= result;
	end

	fpscale_decode u_decode (
		.value_bits(value_s1),
		.scale_exponent(scale_s1),
		.dec(dec)
	);

	fpscale_round u_round (
		.dec(dec),
		.result(result)
	);
endmodule
